@@ rtl/core/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, removable with NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define ASSERT_IMPLIES(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)

`define ASSERT_IMPLIES(lbl, clk, rst_n, pre, post, msg)

`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)

`endif

`endif

@@ rtl/core/sla_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sla_pkg
// Shared types, constants and helpers of the serial line assembler.
// ---------------------------------------------------------------------------
package sla_pkg;

    localparam int DEFAULT_BUFFER_DEPTH = 64;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam int         NIB_BITS = 4;

    localparam logic [1:0] PH_TEXT = 2'd0;
    localparam logic [1:0] PH_HIGH = 2'd1;
    localparam logic [1:0] PH_LOW  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_PACK,
        ST_DRAIN_LOAD,
        ST_DRAIN_OUT
    } sla_state_t;

    typedef struct packed {
        logic       load_byte;
        logic       clear_fill;
        logic       phase_set;
        logic [1:0] phase_val;
        logic       store_byte;
        logic       pack_read;
        logic       pack_write;
        logic       drain_start;
        logic       drain_read;
        logic       out_load;
    } sla_cmd_t;

    typedef struct packed {
        logic       byte_eol;
        logic       byte_print;
        logic       byte_hash;
        logic [1:0] phase;
        logic       fill_zero;
        logic       drain_last;
    } sla_status_t;

    function automatic logic [NIB_BITS-1:0] nibble_of(input logic [7:0] c);
        logic [NIB_BITS-1:0] n;
        n = '0;
        if (c >= 8'h30 && c <= 8'h39)
            n = NIB_BITS'(c - 8'h30);
        else if (c >= 8'h41 && c <= 8'h46)
            n = NIB_BITS'(c - 8'h41 + 8'd10);
        else if (c >= 8'h61 && c <= 8'h66)
            n = NIB_BITS'(c - 8'h61 + 8'd10);
        return n;
    endfunction

endpackage

@@ rtl/core/sla_ctrl.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sla_ctrl
// Sequencer for byte decode, hex packing and line drain.
// ---------------------------------------------------------------------------
module sla_ctrl
    import sla_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        out_ready,
    input  sla_status_t status,
    output logic        in_ready,
    output logic        out_valid,
    output sla_cmd_t    cmd
);

    sla_state_t state_reg;
    sla_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_DECODE;
            end
            ST_DECODE:
            begin
                state_next = ST_IDLE;
                if (status.phase == PH_TEXT)
                begin
                    if (status.byte_eol && !status.fill_zero)
                        state_next = ST_DRAIN_LOAD;
                end
                else if (!status.byte_hash && status.phase == PH_LOW)
                    state_next = ST_PACK;
            end
            ST_PACK:
                state_next = ST_IDLE;
            ST_DRAIN_LOAD:
                state_next = ST_DRAIN_OUT;
            ST_DRAIN_OUT:
            begin
                if (out_ready)
                    state_next = status.drain_last ? ST_IDLE : ST_DRAIN_LOAD;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        cmd       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_byte = in_valid;
            end
            ST_DECODE:
            begin
                if (status.phase == PH_TEXT)
                begin
                    if (!status.byte_eol && !status.byte_print)
                        cmd.clear_fill = 1'b1;
                    else if (status.byte_hash)
                    begin
                        cmd.phase_set = 1'b1;
                        cmd.phase_val = PH_HIGH;
                    end
                    else if (status.byte_eol)
                    begin
                        cmd.clear_fill  = status.fill_zero;
                        cmd.drain_start = !status.fill_zero;
                    end
                    else
                        cmd.store_byte = 1'b1;
                end
                else if (status.byte_hash)
                begin
                    cmd.phase_set = 1'b1;
                    cmd.phase_val = PH_TEXT;
                end
                else if (status.phase == PH_LOW)
                    cmd.pack_read = 1'b1;
                else
                begin
                    cmd.store_byte = 1'b1;
                    cmd.phase_set  = 1'b1;
                    cmd.phase_val  = PH_LOW;
                end
            end
            ST_PACK:
            begin
                cmd.pack_write = 1'b1;
                cmd.phase_set  = 1'b1;
                cmd.phase_val  = PH_HIGH;
            end
            ST_DRAIN_LOAD:
                cmd.out_load = 1'b1;
            ST_DRAIN_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.clear_fill = status.drain_last;
                    cmd.drain_read = !status.drain_last;
                end
            end
            default:
                cmd = '0;
        endcase
    end

endmodule

@@ rtl/core/sla_datapath.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sla_datapath
// Line store, fill count, hex phase, drain index and output register.
// ---------------------------------------------------------------------------
module sla_datapath
    import sla_pkg::*;
#(
    parameter int BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  rx_byte,
    input  sla_cmd_t    cmd,
    output sla_status_t status,
    output logic [7:0]  line_byte
);

    localparam int              AW       = $clog2(BUFFER_DEPTH);
    localparam logic [AW-1:0]   FILL_MAX = AW'(BUFFER_DEPTH - 1);

    logic [7:0]    line_store [BUFFER_DEPTH];
    logic [7:0]    byte_reg;
    logic [7:0]    rd_reg;
    logic [7:0]    out_reg;
    logic [AW-1:0] fill_reg;
    logic [AW-1:0] fill_next;
    logic [AW-1:0] idx_reg;
    logic [AW-1:0] idx_next;
    logic [1:0]    phase_reg;
    logic [1:0]    phase_next;
    logic [AW-1:0] last_addr;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic          wr_en;

    assign last_addr = (fill_reg == '0) ? '0 : fill_reg - AW'(1);

    always_comb
    begin
        rd_en   = cmd.pack_read | cmd.drain_start | cmd.drain_read;
        rd_addr = idx_reg;
        if (cmd.pack_read)
            rd_addr = last_addr;
        else if (cmd.drain_start)
            rd_addr = '0;
        wr_en   = cmd.store_byte | cmd.pack_write;
        wr_addr = cmd.pack_write ? last_addr : fill_reg;
        wr_data = cmd.pack_write ? {nibble_of(rd_reg), nibble_of(byte_reg)} : byte_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            line_store[wr_addr] <= wr_data;
        if (rd_en)
            rd_reg <= line_store[rd_addr];
        if (cmd.load_byte)
            byte_reg <= rx_byte;
        if (cmd.out_load)
            out_reg <= rd_reg;
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (cmd.clear_fill)
            fill_next = '0;
        else if (cmd.store_byte && fill_reg != FILL_MAX)
            fill_next = fill_reg + AW'(1);

        idx_next = idx_reg;
        if (cmd.drain_start)
            idx_next = '0;
        else if (cmd.out_load)
            idx_next = idx_reg + AW'(1);

        phase_next = cmd.phase_set ? cmd.phase_val : phase_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            idx_reg   <= '0;
            phase_reg <= PH_TEXT;
        end
        else
        begin
            fill_reg  <= fill_next;
            idx_reg   <= idx_next;
            phase_reg <= phase_next;
        end
    end

    always_comb
    begin
        status.byte_eol   = (byte_reg == CH_CR) || (byte_reg == CH_LF);
        status.byte_print = (byte_reg >= CH_SPACE) && (byte_reg <= CH_TILDE);
        status.byte_hash  = (byte_reg == CH_HASH);
        status.phase      = phase_reg;
        status.fill_zero  = (fill_reg == '0);
        status.drain_last = (idx_reg == fill_reg);
    end

    assign line_byte = out_reg;

endmodule

@@ rtl/core/serial_line_assembler_hex_escape.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// serial_line_assembler_hex_escape
// Builds command lines from received bytes with a hex escape mode and
// drains each completed line one beat per byte.
//
//   channel | signals                     | carries
//   --------+-----------------------------+------------------------------
//   in      | in_valid, in_ready, rx_byte | one received byte per beat
//   out     | out_valid, out_ready,       | one line byte per beat,
//           | line_byte                   | first byte first
//
// A byte is accepted, then decoded; the low character of a hex pair then
// needs a pack step, as its read-modify-write waits on the registered
// store read. On a line end, each stored byte passes a drain load state
// and a drain output state that holds on output stalls (single read port).
// Reset clears fill count, drain index, hex phase and sequencer; store
// contents persist. No byte is taken while a line drains.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module serial_line_assembler_hex_escape
    import sla_pkg::*;
#(
    parameter int BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] line_byte
);

    sla_cmd_t    cmd;
    sla_status_t status;

    sla_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_ready (out_ready),
        .status    (status),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    sla_datapath #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_byte   (rx_byte),
        .cmd       (cmd),
        .status    (status),
        .line_byte (line_byte)
    );

    `ASSERT_ALWAYS(a_no_overlap, clk, rst_n, !(in_ready && out_valid), "in and out active together")
    `ASSERT_NEXT(a_decode_gap, clk, rst_n, in_valid && in_ready, !in_ready, "byte taken during decode")
    `ASSERT_IMPLIES(a_pack_phase, clk, rst_n, cmd.pack_write, status.phase == PH_LOW, "pack outside low phase")

endmodule
